[rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, muted while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, but it also holds while reset is high
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/afp_pkg.sv]
package afp_pkg;

  localparam logic [7:0] CHAR_END  = 8'h24;
  localparam logic [7:0] CHAR_BAR  = 8'h7C;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [2:0] FIELD_SRC     = 3'd0;
  localparam logic [2:0] FIELD_DST     = 3'd1;
  localparam logic [2:0] FIELD_PAYLOAD = 3'd2;
  localparam logic [2:0] FIELD_LEN     = 3'd3;
  localparam logic [2:0] FIELD_CODE    = 3'd4;
  localparam logic [2:0] FIELD_EXTRA   = 3'd5;

  localparam logic CFG_STATION   = 1'b0;
  localparam logic CFG_BROADCAST = 1'b1;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_ACCEPT    = 3'd1,
    KIND_NOT_ADDR  = 3'd2,
    KIND_CODE      = 3'd3,
    KIND_MALFORMED = 3'd4,
    KIND_OVERFLOW  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_RX,
    ST_EMIT,
    ST_STATUS
  } emit_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  src;
    logic [15:0] len;
  } verdict_t;

endpackage

[rtl/ascii_frame_receiver_with_parity_core.sv]
// channel | direction | transaction
// s_axis  | in        | one received character, tdata[7:0] = rx_byte
// m_axis  | out       | one result: tdata = byte/source/length, tuser = kind, tlast = last
// cfg     | in        | one register write, cfg_index selects station or broadcast
//
// non-terminating characters stream in back to back
// the end marker closes the frame; an accepted frame then reads its stored payload out of
// the ram (registered read), one byte per cycle unless the output stalls, then the status
// receive is held off from the end marker until the status result is in the output register
// synchronous reset clears parser, output and config state; ram contents are not cleared
module ascii_frame_receiver_with_parity_core #(
  parameter int FRAME_BYTES   = 256,
  parameter int PAYLOAD_DEPTH = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] source_address,
                                      // [31:16] declared_length
  output logic        m_axis_tlast,
  output logic [7:0]  m_axis_tuser,   // [2:0] kind, upper bits zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CW = $clog2(PAYLOAD_DEPTH + 1);

  logic [7:0] station_address;
  logic [7:0] broadcast_address;

  logic              busy;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;
  logic              verdict_valid;
  afp_pkg::verdict_t verdict;
  logic [CW-1:0]     verdict_count;
  afp_pkg::kind_t    out_kind;
  logic [7:0]        out_byte;
  logic [7:0]        out_src;
  logic [15:0]       out_len;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !busy;
  assign m_axis_tdata  = {out_len, out_src, out_byte};
  assign m_axis_tuser  = {5'b0, out_kind};

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address   <= 8'd0;
      broadcast_address <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        afp_pkg::CFG_STATION:   station_address   <= cfg_data;
        afp_pkg::CFG_BROADCAST: broadcast_address <= cfg_data;
        default: ;
      endcase
    end
  end

  afp_parser #(
    .FRAME_BYTES  (FRAME_BYTES),
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH),
    .AW           (AW),
    .CW           (CW)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (s_axis_tvalid && s_axis_tready),
    .rx_byte          (s_axis_tdata),
    .station_address  (station_address),
    .broadcast_address(broadcast_address),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .verdict_valid    (verdict_valid),
    .verdict          (verdict),
    .verdict_count    (verdict_count)
  );

  afp_payload_ram #(
    .DEPTH(PAYLOAD_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  afp_emitter #(
    .AW(AW),
    .CW(CW)
  ) u_emitter (
    .clk          (clk),
    .rst          (rst),
    .verdict_valid(verdict_valid),
    .verdict      (verdict),
    .verdict_count(verdict_count),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_src      (out_src),
    .out_len      (out_len),
    .out_last     (m_axis_tlast)
  );

endmodule

[rtl/afp_payload_ram.sv]
module afp_payload_ram #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/afp_parser.sv]
module afp_parser #(
  parameter int FRAME_BYTES   = 256,
  parameter int PAYLOAD_DEPTH = 63,
  parameter int AW            = 6,
  parameter int CW            = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        station_address,
  input  logic [7:0]        broadcast_address,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data,
  output logic              verdict_valid,
  output afp_pkg::verdict_t verdict,
  output logic [CW-1:0]     verdict_count
);

  localparam int FW = $clog2(FRAME_BYTES + 2);

  logic [2:0]    field_position, field_position_next;
  logic [15:0]   header_byte_sum, header_byte_sum_next;
  logic [7:0]    source_value, source_value_next;
  logic [7:0]    destination_value, destination_value_next;
  logic [15:0]   length_value, length_value_next;
  logic [15:0]   code_value, code_value_next;
  logic [CW-1:0] payload_count, payload_count_next;
  logic          overflow_flag, overflow_flag_next;
  logic [FW-1:0] frame_count, frame_count_next;

  logic          ovf_now;
  logic [3:0]    digit;
  logic          is_digit;
  logic [19:0]   len_mac, code_mac;

  assign digit    = 4'(rx_byte - afp_pkg::CHAR_ZERO);
  assign is_digit = rx_byte inside {[afp_pkg::CHAR_ZERO:afp_pkg::CHAR_NINE]};
  assign len_mac  = {4'b0, length_value} * 20'd10 + {16'b0, digit};
  assign code_mac = {4'b0, code_value} * 20'd10 + {16'b0, digit};

  assign wr_addr = payload_count[AW-1:0];
  assign wr_data = rx_byte;

  always_comb begin
    field_position_next    = field_position;
    header_byte_sum_next   = header_byte_sum;
    source_value_next      = source_value;
    destination_value_next = destination_value;
    length_value_next      = length_value;
    code_value_next        = code_value;
    payload_count_next     = payload_count;
    overflow_flag_next     = overflow_flag;
    frame_count_next       = frame_count;
    wr_en                  = 1'b0;
    verdict_valid          = 1'b0;
    verdict.src            = source_value;
    verdict.len            = length_value;
    verdict_count          = payload_count;
    ovf_now                = overflow_flag;

    if (overflow_flag) begin
      verdict.kind = afp_pkg::KIND_OVERFLOW;
    end else if (field_position != afp_pkg::FIELD_CODE) begin
      verdict.kind = afp_pkg::KIND_MALFORMED;
    end else if (destination_value != station_address &&
                 destination_value != broadcast_address) begin
      verdict.kind = afp_pkg::KIND_NOT_ADDR;
    end else if (code_value != {15'b0, ^header_byte_sum}) begin
      verdict.kind = afp_pkg::KIND_CODE;
    end else begin
      verdict.kind = afp_pkg::KIND_ACCEPT;
    end

    if (byte_valid && station_address != 8'd0) begin
      if (frame_count <= FW'(FRAME_BYTES)) begin
        frame_count_next = frame_count + FW'(1);
      end
      ovf_now = overflow_flag || (frame_count_next > FW'(FRAME_BYTES));
      if (ovf_now && !overflow_flag) begin
        verdict.kind = afp_pkg::KIND_OVERFLOW;
      end

      if (rx_byte == afp_pkg::CHAR_END) begin
        verdict_valid          = 1'b1;
        field_position_next    = '0;
        header_byte_sum_next   = '0;
        source_value_next      = '0;
        destination_value_next = '0;
        length_value_next      = '0;
        code_value_next        = '0;
        payload_count_next     = '0;
        overflow_flag_next     = 1'b0;
        frame_count_next       = '0;
      end else begin
        overflow_flag_next = ovf_now;
        // sum covers everything up to, not including, the fourth bar
        if (field_position <= afp_pkg::FIELD_LEN &&
            !(rx_byte == afp_pkg::CHAR_BAR && field_position == afp_pkg::FIELD_LEN)) begin
          header_byte_sum_next = header_byte_sum + {8'b0, rx_byte};
        end
        if (rx_byte == afp_pkg::CHAR_BAR) begin
          if (field_position < afp_pkg::FIELD_EXTRA) begin
            field_position_next = field_position + 3'd1;
          end
        end else if (field_position == afp_pkg::FIELD_PAYLOAD) begin
          if (payload_count < CW'(PAYLOAD_DEPTH)) begin
            wr_en              = 1'b1;
            payload_count_next = payload_count + CW'(1);
          end else begin
            overflow_flag_next = 1'b1;
          end
        end else if (is_digit) begin
          case (field_position)
            afp_pkg::FIELD_SRC: source_value_next = source_value * 8'd10 + {4'b0, digit};
            afp_pkg::FIELD_DST:
              destination_value_next = destination_value * 8'd10 + {4'b0, digit};
            afp_pkg::FIELD_LEN:
              length_value_next = (len_mac > 20'd65535) ? 16'hFFFF : len_mac[15:0];
            afp_pkg::FIELD_CODE:
              code_value_next = (code_mac > 20'd65535) ? 16'hFFFF : code_mac[15:0];
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_position    <= '0;
      header_byte_sum   <= '0;
      source_value      <= '0;
      destination_value <= '0;
      length_value      <= '0;
      code_value        <= '0;
      payload_count     <= '0;
      overflow_flag     <= 1'b0;
      frame_count       <= '0;
    end else begin
      field_position    <= field_position_next;
      header_byte_sum   <= header_byte_sum_next;
      source_value      <= source_value_next;
      destination_value <= destination_value_next;
      length_value      <= length_value_next;
      code_value        <= code_value_next;
      payload_count     <= payload_count_next;
      overflow_flag     <= overflow_flag_next;
      frame_count       <= frame_count_next;
    end
  end

endmodule

[rtl/afp_emitter.sv]
module afp_emitter #(
  parameter int AW = 6,
  parameter int CW = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              verdict_valid,
  input  afp_pkg::verdict_t verdict,
  input  logic [CW-1:0]     verdict_count,
  output logic              busy,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output afp_pkg::kind_t    out_kind,
  output logic [7:0]        out_byte,
  output logic [7:0]        out_src,
  output logic [15:0]       out_len,
  output logic              out_last
);

  afp_pkg::emit_state_t state, state_next;

  afp_pkg::kind_t hold_kind;
  logic [7:0]     hold_src;
  logic [15:0]    hold_len;
  logic [CW-1:0]  hold_count;
  logic [CW-1:0]  idx;
  logic           q_valid;
  logic           out_free;
  logic           load_payload;
  logic           load_status;

  assign out_free = !out_valid || out_ready;
  assign busy     = (state != afp_pkg::ST_RX);
  assign rd_addr  = idx[AW-1:0];

  always_comb begin
    state_next   = state;
    rd_en        = 1'b0;
    load_payload = 1'b0;
    load_status  = 1'b0;
    case (state)
      afp_pkg::ST_RX: begin
        if (verdict_valid) begin
          state_next = (verdict.kind == afp_pkg::KIND_ACCEPT) ? afp_pkg::ST_EMIT
                                                              : afp_pkg::ST_STATUS;
        end
      end
      afp_pkg::ST_EMIT: begin
        load_payload = q_valid && out_free;
        // read data register is free once its byte moves to the output
        rd_en = (idx < hold_count) && (!q_valid || load_payload);
        if (idx == hold_count && !q_valid) begin
          state_next = afp_pkg::ST_STATUS;
        end
      end
      afp_pkg::ST_STATUS: begin
        load_status = out_free;
        if (out_free) begin
          state_next = afp_pkg::ST_RX;
        end
      end
      default: state_next = afp_pkg::ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= afp_pkg::ST_RX;
      q_valid   <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (rd_en) begin
        q_valid <= 1'b1;
        idx     <= idx + CW'(1);
      end else if (load_payload) begin
        q_valid <= 1'b0;
      end
      if (state == afp_pkg::ST_RX) begin
        idx <= '0;
      end
      if (load_payload || load_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == afp_pkg::ST_RX && verdict_valid) begin
      hold_kind  <= verdict.kind;
      hold_src   <= verdict.src;
      hold_len   <= verdict.len;
      hold_count <= verdict_count;
    end
    if (load_payload) begin
      out_kind <= afp_pkg::KIND_PAYLOAD;
      out_byte <= rd_data;
      out_src  <= hold_src;
      out_len  <= hold_len;
      out_last <= 1'b0;
    end else if (load_status) begin
      out_kind <= hold_kind;
      out_byte <= 8'd0;
      out_src  <= hold_src;
      out_len  <= hold_len;
      out_last <= 1'b1;
    end
  end

endmodule

[rtl/afp_checker.sv]
`include "assert_macros.svh"

module afp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [7:0]  m_axis_tuser
);

  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result data changed while stalled")
  // payload bytes never close a frame, every status does
  `ASSERT_CLK(a_last_kind, clk, rst, m_axis_tvalid |-> ((m_axis_tuser[2:0] == afp_pkg::KIND_PAYLOAD) != m_axis_tlast), "tlast does not match kind")
  // payload only comes out while the receive side is held off
  `ASSERT_CLK(a_payload_busy, clk, rst, m_axis_tvalid && m_axis_tuser[2:0] == afp_pkg::KIND_PAYLOAD |-> !s_axis_tready, "payload out while receiving")

endmodule

bind ascii_frame_receiver_with_parity_core afp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

[test/frame_result_checker.sv]
`timescale 1ns / 100ps

module frame_result_checker #(
  parameter int FRAME_BYTES   = 256,
  parameter int PAYLOAD_DEPTH = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [7:0]  m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_total,
  output int          results_due
);

  typedef struct packed {
    afp_pkg::kind_t kind;
    logic [7:0]     data;
    logic [7:0]     src;
    logic [15:0]    len;
    logic           last;
  } frame_result_t;

  frame_result_t due[$];

  logic [7:0]  station;
  logic [7:0]  broadcast;
  logic [2:0]  field_pos;
  logic [15:0] hdr_sum;
  logic [7:0]  src_val;
  logic [7:0]  dst_val;
  logic [15:0] len_val;
  logic [15:0] code_val;
  logic [7:0]  stash [64];
  logic [6:0]  stash_count;
  logic        ovf;
  int          frame_len;
  int          failures = 0;

  function void restart_frame();
    field_pos   = afp_pkg::FIELD_SRC;
    hdr_sum     = 16'd0;
    src_val     = 8'd0;
    dst_val     = 8'd0;
    len_val     = 16'd0;
    code_val    = 16'd0;
    stash_count = 7'd0;
    ovf         = 1'b0;
    frame_len   = 0;
  endfunction

  function logic [15:0] shift_decimal(input logic [15:0] v, input logic [3:0] d);
    int n;
    n = v * 10 + d;
    return (n > 65535) ? 16'hFFFF : n[15:0];
  endfunction

  function void queue_result(input afp_pkg::kind_t k, input logic [7:0] d, input logic l);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.src  = src_val;
    r.len  = len_val;
    r.last = l;
    due.push_back(r);
  endfunction

  function void take_char(input logic [7:0] ch);
    afp_pkg::kind_t verdict;
    logic [3:0]     digit;
    int             i;
    if (station == 8'd0) return;
    if (frame_len <= FRAME_BYTES) frame_len++;
    if (frame_len > FRAME_BYTES) ovf = 1'b1;

    if (ch == afp_pkg::CHAR_END) begin
      if (ovf) verdict = afp_pkg::KIND_OVERFLOW;
      else if (field_pos != afp_pkg::FIELD_CODE) verdict = afp_pkg::KIND_MALFORMED;
      else if (dst_val != station && dst_val != broadcast) verdict = afp_pkg::KIND_NOT_ADDR;
      else if (code_val != {15'd0, ^hdr_sum}) verdict = afp_pkg::KIND_CODE;
      else verdict = afp_pkg::KIND_ACCEPT;
      if (verdict == afp_pkg::KIND_ACCEPT) begin
        for (i = 0; i < stash_count; i++) begin
          queue_result(afp_pkg::KIND_PAYLOAD, stash[i], 1'b0);
        end
      end
      queue_result(verdict, 8'd0, 1'b1);
      restart_frame();
      return;
    end

    // the bar that closes the length field is left out of the sum
    if (field_pos <= afp_pkg::FIELD_LEN &&
        !(ch == afp_pkg::CHAR_BAR && field_pos == afp_pkg::FIELD_LEN))
      hdr_sum = hdr_sum + ch;

    if (ch == afp_pkg::CHAR_BAR) begin
      if (field_pos < afp_pkg::FIELD_EXTRA) field_pos = field_pos + 3'd1;
      return;
    end

    if (field_pos == afp_pkg::FIELD_PAYLOAD) begin
      if (stash_count < PAYLOAD_DEPTH) begin
        stash[stash_count[5:0]] = ch;
        stash_count = stash_count + 7'd1;
      end else begin
        ovf = 1'b1;
      end
      return;
    end

    if (ch >= afp_pkg::CHAR_ZERO && ch <= afp_pkg::CHAR_NINE) begin
      // ascii digits carry their value in the low nibble
      digit = ch[3:0];
      case (field_pos)
        afp_pkg::FIELD_SRC:  src_val  = src_val * 8'd10 + {4'd0, digit};
        afp_pkg::FIELD_DST:  dst_val  = dst_val * 8'd10 + {4'd0, digit};
        afp_pkg::FIELD_LEN:  len_val  = shift_decimal(len_val, digit);
        afp_pkg::FIELD_CODE: code_val = shift_decimal(code_val, digit);
        default: ;
      endcase
    end
  endfunction

  function void report(input string msg);
    failures++;
    if (failures <= 10) $display("%t: %s", $realtime, msg);
  endfunction

  function void check_result();
    frame_result_t want;
    string         seen;
    seen = $sformatf("kind %0d byte %02h src %0d len %0d last %0b", m_axis_tuser,
                     m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[31:16], m_axis_tlast);
    if (due.size() == 0) begin
      report({"unexpected result: ", seen});
      return;
    end
    want = due.pop_front();
    if (m_axis_tuser !== {5'd0, want.kind} || m_axis_tdata[7:0] !== want.data ||
        m_axis_tdata[15:8] !== want.src || m_axis_tdata[31:16] !== want.len ||
        m_axis_tlast !== want.last)
      report($sformatf("mismatch: expected kind %0d byte %02h src %0d len %0d last %0b, got %s",
                       want.kind, want.data, want.src, want.len, want.last, seen));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      station   = 8'd0;
      broadcast = 8'hFF;
      restart_frame();
      due.delete();
    end else begin
      // a result can never come from the character taken at the same edge
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == afp_pkg::CFG_STATION) station = cfg_data;
        else broadcast = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) take_char(s_axis_tdata);
    end
    fail_total  <= failures;
    results_due <= due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int FRAME_BYTES   = 256;
  localparam int PAYLOAD_DEPTH = 63;
  localparam int RANDOM_CHARS  = 190;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [31:0] m_axis_tdata;
  wire         m_axis_tlast;
  wire  [7:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic        cfg_index = afp_pkg::CFG_STATION;
  logic [7:0]  cfg_data = 8'd0;

  int fail_total;
  int results_due;

  int         gap_pct = 0;
  int         stall_pct = 0;
  int         sent = 0;
  int         code_at;
  logic [7:0] own_addr = 8'd0;
  logic [7:0] bcast_addr = 8'hFF;
  logic [7:0] frame_q[$];

  ascii_frame_receiver_with_parity_core #(
    .FRAME_BYTES  (FRAME_BYTES),
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  frame_result_checker #(
    .FRAME_BYTES  (FRAME_BYTES),
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) result_check (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_total   (fail_total),
    .results_due  (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic push_char(input logic [7:0] ch);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) push_char(frame_q[i]);
  endtask

  // hold the sender until every result is out, then let the parser settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] st, input logic [7:0] bc);
    cfg_valid <= 1'b1;
    cfg_index <= afp_pkg::CFG_STATION;
    cfg_data  <= st;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= afp_pkg::CFG_BROADCAST;
    cfg_data  <= bc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    own_addr   = st;
    bcast_addr = bc;
  endtask

  function automatic logic [7:0] pick_char(input bit allow_digit);
    logic [7:0] c;
    do
      c = 8'($urandom_range(255));
    while (c == afp_pkg::CHAR_BAR || c == afp_pkg::CHAR_END ||
           (!allow_digit && c >= afp_pkg::CHAR_ZERO && c <= afp_pkg::CHAR_NINE));
    return c;
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  // decimal text with an occasional leading zero and stray non-digit
  function automatic void add_number(input longint unsigned v);
    string s;
    int    i;
    s = $sformatf("%0d", v);
    if ($urandom_range(3) == 0) frame_q.push_back(afp_pkg::CHAR_ZERO);
    for (i = 0; i < s.len(); i++) begin
      frame_q.push_back(s[i]);
      if ($urandom_range(29) == 0) frame_q.push_back(pick_char(1'b0));
    end
  endfunction

  // the code is the parity of the byte sum up to the closing bar of the length field
  function automatic void finish_frame(input bit wrong_code);
    logic [15:0]     sum;
    longint unsigned code;
    sum = 16'd0;
    foreach (frame_q[i]) sum = sum + frame_q[i];
    frame_q.push_back(afp_pkg::CHAR_BAR);
    code_at = frame_q.size();
    code = {63'd0, ^sum};
    if (wrong_code) code = ($urandom_range(3) == 0) ? 70000 : (code ^ 1);
    add_number(code);
    frame_q.push_back(afp_pkg::CHAR_END);
  endfunction

  // total > 0 gives a clean frame padded with zeros in the code field to that length
  function automatic void build_frame(input int total);
    int              pick;
    int              plen;
    int              i;
    longint unsigned dst;
    frame_q.delete();
    add_number(($urandom_range(3) == 0) ? $urandom_range(99999) : $urandom_range(255));
    frame_q.push_back(afp_pkg::CHAR_BAR);
    pick = $urandom_range(99);
    if (pick < 65 || total > 0) dst = {56'd0, own_addr};
    else if (pick < 80) dst = {56'd0, bcast_addr};
    else if (pick < 85) dst = own_addr + 256 * $urandom_range(1, 50);
    else dst = $urandom_range(255);
    add_number(dst);
    frame_q.push_back(afp_pkg::CHAR_BAR);
    pick = $urandom_range(99);
    if (pick < 92 || total > 0) plen = $urandom_range(8);
    else if (pick < 97) plen = $urandom_range(50, PAYLOAD_DEPTH);
    else plen = $urandom_range(PAYLOAD_DEPTH + 1, PAYLOAD_DEPTH + 8);
    for (i = 0; i < plen; i++) frame_q.push_back(pick_char(1'b1));
    frame_q.push_back(afp_pkg::CHAR_BAR);
    add_number(($urandom_range(7) == 0) ? {$urandom(), $urandom()} : $urandom_range(999));
    finish_frame(total == 0 && $urandom_range(9) == 0);
    if (total > 0) begin
      while (frame_q.size() < total) frame_q.insert(code_at, afp_pkg::CHAR_ZERO);
    end else if ($urandom_range(11) == 0) begin
      // broken framing: drop a bar or add a stray one
      i = $urandom_range(frame_q.size() - 2);
      if (frame_q[i] == afp_pkg::CHAR_BAR) frame_q.delete(i);
      else frame_q.insert(i, afp_pkg::CHAR_BAR);
    end
  endfunction

  initial begin
    int phase;
    int base;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // link inactive: characters are swallowed
    configure(8'd0, 8'hFF);
    frame_q.delete();
    push_text("7|$");
    send_frame();
    quiesce();

    configure(8'd5, 8'hFF);
    frame_q.delete();
    push_text("255|5|");
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    push_text("|9");
    finish_frame(1'b0);
    send_frame();
    frame_q.delete();
    push_text("$");
    send_frame();
    frame_q.delete();
    push_text("|||||$");
    send_frame();

    base = sent;
    for (phase = 0; phase < 4; phase++) begin
      quiesce();
      case (phase)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
          configure(8'd1, 8'hFF);
        end
        1: begin
          gap_pct = 53;
          stall_pct <= 0;
          configure(8'hFF, 8'h00);
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 53;
          configure(8'($urandom_range(2, 254)), 8'($urandom_range(255)));
        end
        default: begin
          gap_pct = 16;
          stall_pct <= 16;
          configure(8'($urandom_range(1, 255)), 8'($urandom_range(255)));
        end
      endcase
      while (sent < base + (phase + 1) * RANDOM_CHARS / 4) begin
        if ($urandom_range(19) == 0) begin
          frame_q.delete();
          repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(255)));
        end else begin
          build_frame(0);
        end
        send_frame();
        if ($urandom_range(9) == 0) quiesce();
      end
    end

    // one character over the frame size limit
    quiesce();
    build_frame(FRAME_BYTES + 1);
    send_frame();

    quiesce();
    if (fail_total == 0 && results_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/afp_pkg.sv
rtl/afp_payload_ram.sv
rtl/afp_parser.sv
rtl/afp_emitter.sv
rtl/ascii_frame_receiver_with_parity_core.sv
rtl/afp_checker.sv
test/frame_result_checker.sv
test/tb.sv
